FILE: hw/rtl/ltm_pkg.sv
package ltm_pkg;

  // request kinds
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // response codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RETRY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  localparam logic [15:0] EXCLUDED_RESET = 16'd9;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [31:0] lock_id;
    logic [15:0] owner;
    logic [31:0] seq_no;
  } entry_t;

endpackage

FILE: hw/rtl/lock_req_if.sv
interface lock_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] lock_id;
  logic [15:0] client_id;
  logic [31:0] seq_no;

  modport source (output valid, output req_type, output lock_id, output client_id,
                  output seq_no, input ready);
  modport sink (input valid, input req_type, input lock_id, input client_id,
                input seq_no, output ready);
endinterface

FILE: hw/rtl/lock_rsp_if.sv
interface lock_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

FILE: hw/rtl/lock_table_manager.sv
// lock table: one comparator sweeps the entry memory, one entry per cycle
// an item is accepted in idle, swept in scan, drained and decided; the response is registered
// (a rejected acquire skips the sweep and goes straight to decide)
// a new item is accepted only in idle, after the previous one is decided
// reset: all entries invalid, excluded client 9, no response pending
module lock_table_manager
  import ltm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  lock_req_if.sink      req,
  lock_rsp_if.source    rsp,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [15:0]              excluded_client;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  entry_t                   entry_mem [TABLE_ENTRIES];
  entry_t                   rd_data;

  // item under work
  logic        cur_release;
  logic [31:0] cur_lock;
  logic [15:0] cur_client;
  logic [31:0] cur_seq;
  logic        cur_rejected;

  // sweep state
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] pipe_idx;
  logic             pipe_vld;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             hit_owner_match;
  logic             hit_seq_match;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic       rsp_valid;
  logic [1:0] rsp_status;

  logic       slot_free;
  logic       decide_go;
  logic [1:0] status_next;
  logic       mem_we;
  logic       valid_clr;
  logic       cmp_hit;

  assign slot_free  = !rsp_valid || rsp.ready;
  assign decide_go  = (state == S_DECIDE) && slot_free;
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign cmp_hit    = pipe_vld && entry_valid[pipe_idx] && (rd_data.lock_id == cur_lock);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and decision
  always_comb begin
    state_next  = state;
    status_next = ST_OK;
    mem_we      = 1'b0;
    valid_clr   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.req_type == REQ_ACQUIRE && req.client_id == excluded_client) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (cur_release) begin
          status_next = ST_OK;
          valid_clr   = hit_found && hit_owner_match;
        end else if (cur_rejected) begin
          status_next = ST_REJECTED;
        end else if (hit_found) begin
          status_next = (hit_owner_match && hit_seq_match) ? ST_OK : ST_RETRY;
        end else if (free_found) begin
          status_next = ST_OK;
          mem_we      = 1'b1;
        end else begin
          status_next = ST_FULL;
        end
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      excluded_client <= EXCLUDED_RESET;
    end else if (cfg_we) begin
      excluded_client <= cfg_wdata;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (decide_go && mem_we) begin
      entry_mem[free_idx] <= '{lock_id: cur_lock, owner: cur_client, seq_no: cur_seq};
    end
    rd_data <= entry_mem[scan_idx];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (decide_go) begin
      if (mem_we) begin
        entry_valid[free_idx] <= 1'b1;
      end else if (valid_clr) begin
        entry_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // capture the item and run the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld   <= 1'b0;
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      pipe_vld <= (state == S_SCAN);
      if (req.valid && req.ready) begin
        cur_release  <= (req.req_type == REQ_RELEASE);
        cur_lock     <= req.lock_id;
        cur_client   <= req.client_id;
        cur_seq      <= req.seq_no;
        cur_rejected <= (req.req_type == REQ_ACQUIRE) && (req.client_id == excluded_client);
        scan_idx     <= '0;
        hit_found    <= 1'b0;
        free_found   <= 1'b0;
      end
      if (state == S_SCAN) begin
        pipe_idx <= scan_idx;
        if (scan_idx != LAST_IDX) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      // compare stage: first matching entry and first free entry
      if (cmp_hit && !hit_found) begin
        hit_found       <= 1'b1;
        hit_idx         <= pipe_idx;
        hit_owner_match <= (rd_data.owner == cur_client);
        hit_seq_match   <= (rd_data.seq_no == cur_seq);
      end
      if (pipe_vld && !entry_valid[pipe_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pipe_idx;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (decide_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      rsp_status <= status_next;
    end
  end

endmodule

FILE: tb/sv/lock_table_manager_tb.sv
module lock_table_manager_tb;
  import ltm_pkg::*;

  localparam int DEPTH      = 16;
  localparam int PHASE_LEN  = 390;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE_CYC = 3 * (DEPTH + 3);

  // one request as the sender offers it
  typedef struct packed {
    logic        req_type;
    logic [31:0] lock_id;
    logic [15:0] client_id;
    logic [31:0] seq_no;
  } lock_req_t;

  // lock table predictor and queue of awaited response codes
  class lock_scoreboard;
    logic [15:0] excluded;
    bit          held [DEPTH];
    entry_t      slot [DEPTH];
    logic [1:0]  status_q [$];
    int          errors;

    function new();
      excluded = EXCLUDED_RESET;
      errors   = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function int find_lock(logic [31:0] id);
      for (int i = 0; i < DEPTH; i++) begin
        if (held[i] && slot[i].lock_id == id) return i;
      end
      return -1;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // apply one accepted item to the table and queue its status
    function void note_request(lock_req_t r);
      int         hit;
      int         spare;
      logic [1:0] st;
      hit   = find_lock(r.lock_id);
      spare = -1;
      st    = ST_OK;
      if (r.req_type == REQ_RELEASE) begin
        if (hit >= 0 && slot[hit].owner == r.client_id) held[hit] = 1'b0;
      end else if (r.client_id == excluded) begin
        st = ST_REJECTED;
      end else if (hit >= 0) begin
        if (!(slot[hit].owner == r.client_id && slot[hit].seq_no == r.seq_no))
          st = ST_RETRY;
      end else begin
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (!held[i]) spare = i;
        end
        if (spare < 0) begin
          st = ST_FULL;
        end else begin
          held[spare]         = 1'b1;
          slot[spare].lock_id = r.lock_id;
          slot[spare].owner   = r.client_id;
          slot[spare].seq_no  = r.seq_no;
        end
      end
      status_q.push_back(st);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_status(logic [1:0] got);
      logic [1:0] want;
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("response status %0d with nothing outstanding", got));
      end else begin
        want = status_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("status %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  lock_req_if req ();
  lock_rsp_if rsp ();

  lock_table_manager #(
    .TABLE_ENTRIES(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lock_scoreboard sb = new();

  bit          calm;
  bit          hold_go;
  logic [31:0] lock_pool [20];
  logic [15:0] client_pool [6];

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // safety net on a hung run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // response side: random back-pressure, one long hold-off on request
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
      end
    end
  end

  // response check
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_status(rsp.status);
  end

  // offer one item and hold it until taken
  task automatic send(input lock_req_t r);
    int gap = 0;
    if (!calm && $urandom_range(99) < 40) gap = $urandom_range(16, 1);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= r.req_type;
    req.lock_id   <= r.lock_id;
    req.client_id <= r.client_id;
    req.seq_no    <= r.seq_no;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_fields(input logic kind, input logic [31:0] id,
                             input logic [15:0] client, input logic [31:0] seq);
    lock_req_t r;
    r.req_type  = kind;
    r.lock_id   = id;
    r.client_id = client;
    r.seq_no    = seq;
    send(r);
  endtask

  // stop offering and wait for every response
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_excluded(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.excluded = v;
  endtask

  // mostly well-formed lock traffic drawn from small pools, some noise
  task automatic pick_item(output lock_req_t r);
    int k;
    int e;
    k = $urandom_range(99);
    r.req_type  = REQ_ACQUIRE;
    r.lock_id   = lock_pool[$urandom_range(19)];
    r.client_id = client_pool[$urandom_range(5)];
    r.seq_no    = $urandom();
    if (k < 30) begin
      // fresh acquire
    end else if (k < 50) begin
      // repeat of the holder's acquire
      e = sb.find_lock(r.lock_id);
      if (e >= 0) begin
        r.client_id = sb.slot[e].owner;
        r.seq_no    = sb.slot[e].seq_no;
      end
    end else if (k < 72) begin
      // release by the owner of some held entry
      r.req_type = REQ_RELEASE;
      e = $urandom_range(DEPTH - 1);
      if (sb.held[e]) begin
        r.lock_id   = sb.slot[e].lock_id;
        r.client_id = sb.slot[e].owner;
      end
    end else if (k < 82) begin
      r.req_type = REQ_RELEASE;
    end else if (k < 87) begin
      r.client_id = sb.excluded;
    end else begin
      r.req_type  = 1'($urandom_range(1));
      r.lock_id   = $urandom();
      r.client_id = 16'($urandom_range(65535));
    end
  endtask

  // stimulus
  initial begin
    lock_req_t   r;
    logic [15:0] phase_excl [5];
    req.valid     <= 1'b0;
    req.req_type  <= REQ_ACQUIRE;
    req.lock_id   <= '0;
    req.client_id <= '0;
    req.seq_no    <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    calm          = 1'b0;
    hold_go       = 1'b0;
    rst           <= 1'b1;

    lock_pool[0] = 32'h0000_0000;
    lock_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 20; i++) lock_pool[i] = $urandom();
    client_pool[0] = 16'h0000;
    client_pool[1] = 16'hFFFF;
    client_pool[2] = EXCLUDED_RESET;
    for (int i = 3; i < 6; i++) client_pool[i] = 16'($urandom_range(65535));
    phase_excl[0] = 16'h0000;
    phase_excl[1] = 16'hFFFF;
    phase_excl[2] = 16'($urandom_range(65535));
    phase_excl[3] = EXCLUDED_RESET;
    phase_excl[4] = client_pool[3];

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: grant, repeat, retry, extremes, exclusion, releases
    send_fields(REQ_ACQUIRE, 32'h0, 16'h0, 32'h0);
    send_fields(REQ_ACQUIRE, 32'h0, 16'h0, 32'h0);
    send_fields(REQ_ACQUIRE, 32'h0, 16'h0, 32'h1);
    send_fields(REQ_ACQUIRE, 32'h0, 16'h1, 32'h0);
    send_fields(REQ_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(REQ_ACQUIRE, 32'h5, EXCLUDED_RESET, 32'h5);
    send_fields(REQ_RELEASE, 32'h0, 16'h1, 32'h0);
    send_fields(REQ_ACQUIRE, 32'h0, 16'h1, 32'h0);
    send_fields(REQ_RELEASE, 32'd12345, 16'h3, 32'h0);
    send_fields(REQ_ACQUIRE, 32'd12345, 16'h3, 32'h2);
    send_fields(REQ_RELEASE, 32'h0, 16'h0, 32'h0);
    send_fields(REQ_ACQUIRE, 32'h0, 16'h1, 32'h7);
    // fill the table, then probe it while full
    for (int i = 0; i < DEPTH - 3; i++) send_fields(REQ_ACQUIRE, 32'd100 + i, 16'h2, i);
    send_fields(REQ_ACQUIRE, 32'd200, 16'h2, 32'h0);
    send_fields(REQ_ACQUIRE, 32'd100, 16'h2, 32'h0);
    send_fields(REQ_ACQUIRE, 32'd101, 16'h4, 32'h1);
    send_fields(REQ_ACQUIRE, 32'd300, EXCLUDED_RESET, 32'h0);

    // random phases, each under its own excluded client
    for (int p = 0; p < 5; p++) begin
      drain();
      write_excluded(phase_excl[p]);
      if (p == 1) hold_go = 1'b1;
      calm = (p == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 3 && n == PHASE_LEN / 2) drain();
        pick_item(r);
        send(r);
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ltm_pkg.sv
hw/rtl/lock_req_if.sv
hw/rtl/lock_rsp_if.sv
hw/rtl/lock_table_manager.sv
tb/sv/lock_table_manager_tb.sv
